// ----- rtl/sts_pkg.sv -----
package sts_pkg;

    // field widths
    localparam int SIZE_W   = 8;
    localparam int COORD_W  = 17;
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = 33;
    localparam int PIXEL_W  = 32;
    localparam int CHAN_W   = 8;
    localparam int LIN_W    = 2 * SIZE_W + 1;
    localparam int CFG_IDX_W = 2;

    // parameter defaults
    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;

    // remainder unit: bits retired per cycle and cycle count
    localparam int MOD_BITS   = 4;
    localparam int MOD_CYCLES = (COORD_W + MOD_BITS - 1) / MOD_BITS;
    localparam int MAG_W      = MOD_CYCLES * MOD_BITS;

    localparam int JOB_QUEUE_DEPTH = 2;

    localparam logic [PIXEL_W-1:0] OPAQUE_BLACK = 32'hFF00_0000;
    localparam logic [CHAN_W-1:0]  CHAN_FULL    = 8'hFF;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_MODE     = 2'd2;

    typedef enum logic [1:0] {
        KIND_WRITE    = 2'd0,
        KIND_POINT    = 2'd1,
        KIND_NEAREST  = 2'd2,
        KIND_BILINEAR = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic signed [15:0]  col;
        logic signed [15:0]  row;
        logic signed [23:0]  u_coord;
        logic signed [23:0]  v_coord;
        logic [PIXEL_W-1:0]  write_pixel;
    } in_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic              accepted;
    } out_item_t;

    // effective sprite geometry
    typedef struct packed {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic              wrap;
    } cfg_t;

    // classified work handed from front to back
    typedef struct packed {
        kind_t                      kind;
        logic signed [COORD_W-1:0]  x0;
        logic signed [COORD_W-1:0]  x1;
        logic signed [COORD_W-1:0]  y0;
        logic signed [COORD_W-1:0]  y1;
        logic [FRAC_W-1:0]          fu;
        logic [FRAC_W-1:0]          fv;
        logic [PIXEL_W-1:0]         wpix;
    } job_t;

    // queue handshake
    typedef struct packed {
        logic push;
        logic full;
        logic pop;
        logic empty;
    } queue_ctl_t;

endpackage

// ----- rtl/sts_stream_if.sv -----
interface sts_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/sts_absmod.sv -----
module sts_absmod
    import sts_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [COORD_W-1:0]  value,
    input  logic [SIZE_W-1:0]          divisor,
    output logic                       busy,
    output logic [SIZE_W-1:0]          rem
);

    localparam int CNT_W = (MOD_CYCLES > 1) ? $clog2(MOD_CYCLES) : 1;

    logic                busy_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [MAG_W-1:0]    dv_reg;
    logic [MAG_W-1:0]    dv_next;
    logic [SIZE_W-1:0]   rem_reg;
    logic [SIZE_W-1:0]   rem_next;
    logic [COORD_W-1:0]  mag;

    assign mag = value[COORD_W-1] ? COORD_W'(-value) : COORD_W'(value);

    // restoring remainder, a few dividend bits per cycle
    always_comb
    begin
        logic [SIZE_W:0]   t;
        logic [SIZE_W-1:0] r;
        logic [MAG_W-1:0]  d;
        r = rem_reg;
        d = dv_reg;
        for (int i = 0; i < MOD_BITS; i++)
        begin
            t = {r, d[MAG_W-1]};
            d = {d[MAG_W-2:0], 1'b0};
            if (t >= {1'b0, divisor})
            begin
                t = t - {1'b0, divisor};
            end
            r = t[SIZE_W-1:0];
        end
        rem_next = r;
        dv_next  = d;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(MOD_CYCLES - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dv_reg  <= MAG_W'(mag);
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dv_reg  <= dv_next;
            rem_reg <= rem_next;
        end
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

endmodule

// ----- rtl/sts_queue.sv -----
module sts_queue
    import sts_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t pop_job,
    output logic full,
    output logic empty
);

    localparam int PTR_W = (JOB_QUEUE_DEPTH > 1) ? $clog2(JOB_QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(JOB_QUEUE_DEPTH + 1);

    job_t             entry_reg [JOB_QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full    = (cnt_reg == CNT_W'(JOB_QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign pop_job = entry_reg[rd_ptr_reg];

    // depth is a power of two, pointers wrap naturally
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- rtl/sts_front.sv -----
module sts_front
    import sts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        enable,
    sts_stream_if.sink  request,
    output logic        push,
    output job_t        push_job,
    input  logic        full
);

    localparam logic signed [PROD_W-1:0] TRUNC_ADJ = PROD_W'(65535);
    localparam logic signed [PROD_W-1:0] HALF_TEXEL = PROD_W'(32768);

    logic                       stage_valid_reg;
    kind_t                      kind_reg;
    logic signed [15:0]         col_reg;
    logic signed [15:0]         row_reg;
    logic signed [PROD_W-1:0]   prod_u_reg;
    logic signed [PROD_W-1:0]   prod_v_reg;
    logic [PIXEL_W-1:0]         wpix_reg;
    logic                       accept;

    function automatic logic signed [COORD_W-1:0] size_limit(input logic [SIZE_W-1:0] size);
        return $signed({{(COORD_W-SIZE_W){1'b0}}, size - SIZE_W'(1)});
    endfunction

    // truncate toward zero and cap at size-1
    function automatic logic signed [COORD_W-1:0] nearest_idx(
        input logic signed [PROD_W-1:0] prod,
        input logic [SIZE_W-1:0]        size
    );
        logic signed [PROD_W-1:0]  adj;
        logic signed [COORD_W-1:0] t;
        logic signed [COORD_W-1:0] lim;
        adj = prod[PROD_W-1] ? prod + TRUNC_ADJ : prod;
        t   = adj[PROD_W-1:FRAC_W];
        lim = size_limit(size);
        return (t > lim) ? lim : t;
    endfunction

    assign accept        = request.valid && request.ready;
    assign request.ready = enable && (!stage_valid_reg || !full);
    assign push          = stage_valid_reg && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= request.payload.kind;
            col_reg    <= request.payload.col;
            row_reg    <= request.payload.row;
            wpix_reg   <= request.payload.write_pixel;
            prod_u_reg <= request.payload.u_coord * $signed({1'b0, cfg.width});
            prod_v_reg <= request.payload.v_coord * $signed({1'b0, cfg.height});
        end
    end

    always_comb
    begin
        logic signed [PROD_W-1:0]  pu;
        logic signed [PROD_W-1:0]  pv;
        logic signed [COORD_W-1:0] xi;
        logic signed [COORD_W-1:0] yi;
        logic signed [COORD_W-1:0] xn;
        logic signed [COORD_W-1:0] yn;
        logic signed [COORD_W-1:0] limx;
        logic signed [COORD_W-1:0] limy;
        pu   = prod_u_reg - HALF_TEXEL;
        pv   = prod_v_reg - HALF_TEXEL;
        xi   = pu[PROD_W-1:FRAC_W];
        yi   = pv[PROD_W-1:FRAC_W];
        xn   = xi + COORD_W'(1);
        yn   = yi + COORD_W'(1);
        limx = size_limit(cfg.width);
        limy = size_limit(cfg.height);

        push_job      = '0;
        push_job.kind = kind_reg;
        push_job.wpix = wpix_reg;
        unique case (kind_reg)
            KIND_WRITE, KIND_POINT:
            begin
                push_job.x0 = COORD_W'(col_reg);
                push_job.y0 = COORD_W'(row_reg);
            end
            KIND_NEAREST:
            begin
                push_job.x0 = nearest_idx(prod_u_reg, cfg.width);
                push_job.y0 = nearest_idx(prod_v_reg, cfg.height);
            end
            KIND_BILINEAR:
            begin
                // lower neighbor clamped at zero, upper at the far edge
                push_job.x0 = xi[COORD_W-1] ? '0 : xi;
                push_job.y0 = yi[COORD_W-1] ? '0 : yi;
                push_job.x1 = (xn < limx) ? xn : limx;
                push_job.y1 = (yn < limy) ? yn : limy;
                push_job.fu = pu[FRAC_W-1:0];
                push_job.fv = pv[FRAC_W-1:0];
            end
            default:
            begin
                push_job.x0 = '0;
            end
        endcase
    end

endmodule

// ----- rtl/sts_back.sv -----
module sts_back
    import sts_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  job_t          job,
    input  logic          empty,
    output logic          pop,
    output logic          clearing,
    sts_stream_if.source  response
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TOP_W  = CHAN_W + FRAC_W;
    localparam int H_W    = CHAN_W + FRAC_W + 2;
    localparam int V_W    = TOP_W + FRAC_W + 2;

    typedef enum logic [9:0] {
        ST_CLEAR  = 10'b00_0000_0001,
        ST_IDLE   = 10'b00_0000_0010,
        ST_FETCH  = 10'b00_0000_0100,
        ST_MOD    = 10'b00_0000_1000,
        ST_ADDR   = 10'b00_0001_0000,
        ST_MEM    = 10'b00_0010_0000,
        ST_CAPT   = 10'b00_0100_0000,
        ST_BLEND1 = 10'b00_1000_0000,
        ST_BLEND2 = 10'b01_0000_0000,
        ST_DONE   = 10'b10_0000_0000
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    job_t                       job_reg;
    logic [1:0]                 fidx_reg;
    logic [SIZE_W-1:0]          ax_reg;
    logic [SIZE_W-1:0]          ay_reg;
    logic                       inb_reg;
    logic [ADDR_W-1:0]          addr_reg;
    logic [ADDR_W-1:0]          clr_addr_reg;
    logic [PIXEL_W-1:0]         pix_reg [4];
    logic [TOP_W-1:0]           top_reg [3];
    logic [TOP_W-1:0]           bot_reg [3];
    logic [CHAN_W-1:0]          chan_reg [3];
    logic [PIXEL_W-1:0]         mem [DEPTH];
    logic [PIXEL_W-1:0]         rdata_reg;
    logic                       out_valid_reg;
    out_item_t                  out_reg;
    out_item_t                  out_next;

    logic signed [COORD_W-1:0]  cx;
    logic signed [COORD_W-1:0]  cy;
    logic                       clamp_inb;
    logic                       need_mod;
    logic                       mod_start;
    logic                       busy_x;
    logic                       busy_y;
    logic [SIZE_W-1:0]          rem_x;
    logic [SIZE_W-1:0]          rem_y;
    logic [LIN_W-1:0]           lin;
    logic                       mem_we;
    logic                       mem_re;
    logic [ADDR_W-1:0]          mem_addr;
    logic [PIXEL_W-1:0]         mem_wdata;
    logic                       out_load;
    logic                       is_bilinear;

    assign is_bilinear = (job_reg.kind == KIND_BILINEAR);
    assign cx = fidx_reg[0] ? job_reg.x1 : job_reg.x0;
    assign cy = fidx_reg[1] ? job_reg.y1 : job_reg.y0;
    assign clamp_inb = !cx[COORD_W-1] && (cx < $signed({1'b0, {(COORD_W-SIZE_W-1){1'b0}}, cfg.width}))
                    && !cy[COORD_W-1] && (cy < $signed({1'b0, {(COORD_W-SIZE_W-1){1'b0}}, cfg.height}));
    assign need_mod  = cfg.wrap && (job_reg.kind != KIND_WRITE);
    assign mod_start = (state_reg == ST_FETCH) && need_mod;
    assign lin = LIN_W'(ay_reg) * LIN_W'(cfg.width) + LIN_W'(ax_reg);

    sts_absmod u_mod_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mod_start),
        .value   (cx),
        .divisor (cfg.width),
        .busy    (busy_x),
        .rem     (rem_x)
    );

    sts_absmod u_mod_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mod_start),
        .value   (cy),
        .divisor (cfg.height),
        .busy    (busy_y),
        .rem     (rem_y)
    );

    assign out_load = !out_valid_reg || response.ready;
    assign pop      = (state_reg == ST_IDLE) && !empty;
    assign clearing = (state_reg == ST_CLEAR);

    assign mem_we    = clearing || ((state_reg == ST_MEM) && (job_reg.kind == KIND_WRITE) && inb_reg);
    assign mem_re    = (state_reg == ST_MEM) && (job_reg.kind != KIND_WRITE);
    assign mem_addr  = clearing ? clr_addr_reg : addr_reg;
    assign mem_wdata = clearing ? OPAQUE_BLACK : job_reg.wpix;

    // single-port pixel store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!empty)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = need_mod ? ST_MOD : ST_ADDR;
            end
            ST_MOD:
            begin
                if (!busy_x && !busy_y)
                begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                state_next = ST_MEM;
            end
            ST_MEM:
            begin
                state_next = (job_reg.kind == KIND_WRITE) ? ST_DONE : ST_CAPT;
            end
            ST_CAPT:
            begin
                if (is_bilinear && fidx_reg != 2'd3)
                begin
                    state_next = ST_FETCH;
                end
                else if (is_bilinear)
                begin
                    state_next = ST_BLEND1;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_BLEND1:
            begin
                state_next = ST_BLEND2;
            end
            ST_BLEND2:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            fidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (pop)
            begin
                fidx_reg <= '0;
            end
            else if (state_reg == ST_CAPT)
            begin
                fidx_reg <= fidx_reg + 2'd1;
            end
            if ((state_reg == ST_DONE) && out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (response.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= job;
        end
        if ((state_reg == ST_FETCH) && !need_mod)
        begin
            ax_reg  <= cx[SIZE_W-1:0];
            ay_reg  <= cy[SIZE_W-1:0];
            inb_reg <= clamp_inb;
        end
        if ((state_reg == ST_MOD) && !busy_x && !busy_y)
        begin
            ax_reg  <= rem_x;
            ay_reg  <= rem_y;
            inb_reg <= 1'b1;
        end
        if (state_reg == ST_ADDR)
        begin
            addr_reg <= ADDR_W'(lin);
        end
        if (state_reg == ST_CAPT)
        begin
            pix_reg[fidx_reg] <= inb_reg ? rdata_reg : '0;
        end
    end

    // two-pass blend: horizontal lerps, then vertical lerp
    always_ff @(posedge clk)
    begin
        logic signed [CHAN_W:0]  d;
        logic signed [H_W-1:0]   h_top;
        logic signed [H_W-1:0]   h_bot;
        logic signed [TOP_W:0]   dv;
        logic signed [V_W-1:0]   s;
        for (int ch = 0; ch < 3; ch++)
        begin
            if (state_reg == ST_BLEND1)
            begin
                d = $signed({1'b0, pix_reg[1][CHAN_W*ch +: CHAN_W]})
                  - $signed({1'b0, pix_reg[0][CHAN_W*ch +: CHAN_W]});
                h_top = $signed({2'b00, pix_reg[0][CHAN_W*ch +: CHAN_W], {FRAC_W{1'b0}}})
                      + d * $signed({1'b0, job_reg.fu});
                d = $signed({1'b0, pix_reg[3][CHAN_W*ch +: CHAN_W]})
                  - $signed({1'b0, pix_reg[2][CHAN_W*ch +: CHAN_W]});
                h_bot = $signed({2'b00, pix_reg[2][CHAN_W*ch +: CHAN_W], {FRAC_W{1'b0}}})
                      + d * $signed({1'b0, job_reg.fu});
                top_reg[ch] <= h_top[TOP_W-1:0];
                bot_reg[ch] <= h_bot[TOP_W-1:0];
            end
            if (state_reg == ST_BLEND2)
            begin
                dv = $signed({1'b0, bot_reg[ch]}) - $signed({1'b0, top_reg[ch]});
                s  = $signed({2'b00, top_reg[ch], {FRAC_W{1'b0}}})
                   + dv * $signed({1'b0, job_reg.fv});
                chan_reg[ch] <= s[2*FRAC_W +: CHAN_W];
            end
        end
    end

    // result word for the finished job
    always_comb
    begin
        out_next = '0;
        unique case (job_reg.kind)
            KIND_WRITE:
            begin
                out_next.accepted = inb_reg;
            end
            KIND_BILINEAR:
            begin
                out_next.red   = chan_reg[0];
                out_next.green = chan_reg[1];
                out_next.blue  = chan_reg[2];
                out_next.alpha = CHAN_FULL;
            end
            default:
            begin
                out_next.red   = pix_reg[0][7:0];
                out_next.green = pix_reg[0][15:8];
                out_next.blue  = pix_reg[0][23:16];
                out_next.alpha = pix_reg[0][31:24];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DONE) && out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign response.valid   = out_valid_reg;
    assign response.payload = out_reg;

endmodule

// ----- rtl/sprite_texel_sampler.sv -----
// sprite texel sampler: an rgba sprite store of MAX_WIDTH*MAX_HEIGHT words with
// pixel writes, point reads, nearest samples and bilinear samples, one result
// transaction per request transaction. after reset the block sweeps the store
// to opaque black, one word a cycle; request.ready stays low during the sweep,
// config writes are taken. in the front a request is captured with the
// coordinate scaling multiply, then classified and pushed into a two-deep queue.
// the back engine handles one request at a time: each texel fetch steps through
// resolve, address multiply, read and capture on the single-port store, and in
// wrap mode a read or sample waits for the remainder units between resolve and
// address multiply. a point or nearest read needs one fetch; a bilinear sample
// needs four fetches plus a blend of horizontal lerps, then a vertical lerp.
// the back engine sets the sustained rate, the front overlaps with it, and a
// finished result waits in the output register while the back engine goes on
// with the next job, which holds in its done state until the register is free.
module sprite_texel_sampler
    import sts_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [SIZE_W-1:0]     cfg_data,
    sts_stream_if.sink            request,
    sts_stream_if.source          response
);

    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    logic               wrap_reg;
    cfg_t               cfg;
    queue_ctl_t         qctl;
    job_t               push_job;
    job_t               pop_job;
    logic               clearing;

    // zero acts as one, anything past the store's maximum acts as the maximum
    function automatic logic [SIZE_W-1:0] eff_size(
        input logic [SIZE_W-1:0] r,
        input int                maxv
    );
        logic [SIZE_W-1:0] s;
        if (r == '0)
        begin
            s = SIZE_W'(1);
        end
        else if (int'(r) > maxv)
        begin
            s = SIZE_W'(maxv);
        end
        else
        begin
            s = r;
        end
        return s;
    endfunction

    // config registers, to be written only while the block is idle; not enforced here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_W'(128);
            height_reg <= SIZE_W'(128);
            wrap_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_SPRITE_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            else if (cfg_index == REG_SPRITE_HEIGHT)
            begin
                height_reg <= cfg_data;
            end
            else if (cfg_index == REG_WRAP_MODE)
            begin
                wrap_reg <= cfg_data[0];
            end
        end
    end

    assign cfg.width  = eff_size(width_reg, MAX_WIDTH);
    assign cfg.height = eff_size(height_reg, MAX_HEIGHT);
    assign cfg.wrap   = wrap_reg;

    // front: capture, scale and classify into fetch coordinates
    sts_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .enable   (!clearing),
        .request  (request),
        .push     (qctl.push),
        .push_job (push_job),
        .full     (qctl.full)
    );

    // short queue decoupling front and back
    sts_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (qctl.push),
        .push_job (push_job),
        .pop      (qctl.pop),
        .pop_job  (pop_job),
        .full     (qctl.full),
        .empty    (qctl.empty)
    );

    // back: store access, wrap remainders, blending and result register
    sts_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .job      (pop_job),
        .empty    (qctl.empty),
        .pop      (qctl.pop),
        .clearing (clearing),
        .response (response)
    );

endmodule
